// ===== hdl/i2cms_pkg.sv =====
// Package for the I2C master bit sequencer: command codes, field widths,
// and the item and result structs shared by the sequencer files.
// No dependencies.
package i2cms_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned BITCNT_W   = 4;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 16;

    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(BYTE_W);

    typedef enum logic [OP_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6,
        CMD_WAIT  = 3'd7
    } cmd_t;

    typedef struct packed {
        logic              sda_in;
        logic [BYTE_W-1:0] tx_byte;
        cmd_t              op;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_seen;
        logic              status;
        logic              done_res;
        logic              busy_res;
        logic              sda_drive;
        logic              scl_drive;
    } result_t;

endpackage

// ===== hdl/i2cms_step.sv =====
// Sequencer state and per-tick step logic for the I2C master bit sequencer.
// Advances one bus phase per fired item. Depends on i2cms_pkg.
module i2cms_step
    import i2cms_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    cmd_t                cmd_reg, cmd_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [BITCNT_W-1:0] bit_reg, bit_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_reg, ack_next;

    logic                launch;
    cmd_t                cmd_eff;
    logic [PHASE_W-1:0]  ph;
    logic [BITCNT_W-1:0] bc;
    logic [BYTE_W-1:0]   sh;
    logic                done;
    logic                wrap;
    logic                bits_done;

    assign launch    = (cmd_reg == CMD_NONE) && (item.op != CMD_NONE);
    assign cmd_eff   = launch ? item.op : cmd_reg;
    assign ph        = launch ? '0 : phase_reg;
    assign bc        = launch ? '0 : bit_reg;
    assign sh        = launch ? ((item.op == CMD_WRITE) ? item.tx_byte : '0) : shift_reg;
    assign bits_done = (bc >= BITS_PER_BYTE);

    // sequence control: completion, phase and bit counters
    always_comb begin
        done = 1'b0;
        wrap = 1'b0;
        case (cmd_eff)
            CMD_NONE: begin
                done = 1'b0;
            end
            CMD_START: begin
                done = (ph == 2'd1) ? !item.sda_in : (ph >= 2'd2);
            end
            CMD_STOP: begin
                done = (ph >= 2'd2);
            end
            CMD_ACK, CMD_NACK, CMD_WAIT: begin
                done = (ph == 2'd3);
            end
            CMD_WRITE: begin
                done = bits_done;
                wrap = !bits_done && (ph >= 2'd2);
            end
            CMD_READ: begin
                done = bits_done;
                wrap = !bits_done && (ph != 2'd0);
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (cmd_eff == CMD_NONE) begin
            cmd_next   = cmd_reg;
            phase_next = phase_reg;
            bit_next   = bit_reg;
        end else if (done) begin
            cmd_next   = CMD_NONE;
            phase_next = '0;
            bit_next   = '0;
        end else begin
            cmd_next   = cmd_eff;
            phase_next = wrap ? '0 : ph + 1'b1;
            bit_next   = wrap ? bc + 1'b1 : bc;
        end
    end

    // line levels, shift register and result fields
    always_comb begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        shift_next = (cmd_eff == CMD_NONE) ? shift_reg : sh;
        res        = '0;
        case (cmd_eff)
            CMD_START: begin
                if (ph == 2'd0) begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end else if (ph == 2'd1) begin
                    res.status = !item.sda_in;
                    if (item.sda_in) begin
                        sda_next = 1'b0;
                    end
                end else begin
                    scl_next = 1'b0;
                end
            end
            CMD_STOP: begin
                if (ph == 2'd0) begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end else if (ph == 2'd1) begin
                    scl_next = 1'b1;
                end else begin
                    sda_next = 1'b1;
                end
            end
            CMD_ACK, CMD_NACK, CMD_WAIT: begin
                if (ph == 2'd0) begin
                    scl_next = 1'b0;
                end else if (ph == 2'd1) begin
                    sda_next = (cmd_eff != CMD_ACK);
                end else if (ph == 2'd2) begin
                    scl_next = 1'b1;
                end else begin
                    scl_next = 1'b0;
                    if (cmd_eff == CMD_WAIT) begin
                        ack_next = !item.sda_in;
                    end
                end
            end
            CMD_WRITE: begin
                if (bits_done || ph == 2'd0) begin
                    scl_next = 1'b0;
                end else if (ph == 2'd1) begin
                    sda_next   = sh[BYTE_W-1];
                    shift_next = {sh[BYTE_W-2:0], 1'b0};
                end else begin
                    scl_next = 1'b1;
                end
            end
            CMD_READ: begin
                if (bits_done) begin
                    shift_next  = {sh[BYTE_W-2:0], item.sda_in};
                    scl_next    = 1'b0;
                    res.rx_byte = shift_next;
                end else if (ph == 2'd0) begin
                    if (bc == '0) begin
                        sda_next = 1'b1;
                    end else begin
                        shift_next = {sh[BYTE_W-2:0], item.sda_in};
                    end
                    scl_next = 1'b0;
                end else begin
                    scl_next = 1'b1;
                end
            end
            default: begin
                scl_next = scl_reg;
            end
        endcase
        res.scl_drive = scl_next;
        res.sda_drive = sda_next;
        res.busy_res  = (cmd_eff != CMD_NONE) && !done;
        res.done_res  = done;
        res.ack_seen  = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_NONE;
            phase_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
        end else if (fire) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

// ===== hdl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: input register, step logic and
// result register. Depends on i2cms_pkg and i2cms_step.
// The result passes through the input register and then the result register on its way to m_tdata.
// Throughput: one transaction per cycle, one sequencer tick each; stalls only on m_tready.
// Reset: synchronous, active low; empties both stages, sequencer goes idle
// with SCL and SDA released and the ack result cleared.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // op[2:0], tx_byte[10:3], sda_in[11], zero[15:12]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // scl_drive[0], sda_drive[1], busy_res[2],
                                           // done_res[3], status[4], ack_seen[5],
                                           // rx_byte[13:6], zero[15:14]
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    out_ready;
    logic    fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    i2cms_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

// ===== hdl/i2cms_checker.sv =====
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends only on the top-level ports.
module i2cms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("busy and done together");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3] && m_tdata[1] && m_tdata[0])
        else $error("bus-busy status without done and released lines");

    a_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[13:6] != 8'd0) |-> m_tdata[3] && !m_tdata[0])
        else $error("received byte outside a read completion");

    a_first: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);

// ===== verif/i2c_master_bit_sequencer_tb.sv =====
// Testbench for i2c_master_bit_sequencer: directed command table, then a long
// random tick stream with random stalls on both channels, scored against a cycle-accurate
// line model or a table row's own expected result. Depends on i2cms_pkg and the sequencer RTL.
module i2c_master_bit_sequencer_tb;
    import i2cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_TICKS = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam result_t IDLE_LINES = '{rx_byte: 8'h00, ack_seen: 1'b0, status: 1'b0,
                                       done_res: 1'b0, busy_res: 1'b0,
                                       sda_drive: 1'b1, scl_drive: 1'b1};
    localparam result_t BUS_HELD_LOW = '{rx_byte: 8'h00, ack_seen: 1'b0, status: 1'b1,
                                         done_res: 1'b1, busy_res: 1'b0,
                                         sda_drive: 1'b1, scl_drive: 1'b1};

    typedef struct packed {
        cmd_t              op;
        logic [BYTE_W-1:0] tx;
        logic              sda;
        logic [4:0]        reps;
        logic              has_want;
        result_t           want;
    } dir_row_t;

    localparam int unsigned DIR_ROWS = 19;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{CMD_NONE,  8'h00, 1'b1, 5'd2,  1'b1, IDLE_LINES},
        '{CMD_START, 8'hFF, 1'b1, 5'd1,  1'b0, IDLE_LINES},
        '{CMD_NONE,  8'h00, 1'b0, 5'd1,  1'b1, BUS_HELD_LOW},
        '{CMD_START, 8'h00, 1'b1, 5'd3,  1'b0, IDLE_LINES},
        '{CMD_WRITE, 8'hFF, 1'b0, 5'd1,  1'b0, IDLE_LINES},
        '{CMD_WRITE, 8'h00, 1'b1, 5'd24, 1'b0, IDLE_LINES},
        '{CMD_WAIT,  8'h00, 1'b0, 5'd4,  1'b0, IDLE_LINES},
        '{CMD_WRITE, 8'h00, 1'b1, 5'd25, 1'b0, IDLE_LINES},
        '{CMD_WAIT,  8'h00, 1'b1, 5'd4,  1'b0, IDLE_LINES},
        '{CMD_WRITE, 8'hA5, 1'b0, 5'd25, 1'b0, IDLE_LINES},
        '{CMD_STOP,  8'h00, 1'b1, 5'd3,  1'b0, IDLE_LINES},
        '{CMD_START, 8'h00, 1'b1, 5'd3,  1'b0, IDLE_LINES},
        '{CMD_READ,  8'h00, 1'b1, 5'd17, 1'b0, IDLE_LINES},
        '{CMD_ACK,   8'hFF, 1'b1, 5'd4,  1'b0, IDLE_LINES},
        '{CMD_READ,  8'hFF, 1'b0, 5'd17, 1'b0, IDLE_LINES},
        '{CMD_NACK,  8'h00, 1'b0, 5'd4,  1'b0, IDLE_LINES},
        '{CMD_STOP,  8'hFF, 1'b0, 5'd3,  1'b0, IDLE_LINES},
        '{CMD_NONE,  8'hFF, 1'b0, 5'd2,  1'b0, IDLE_LINES},
        '{CMD_NONE,  8'h00, 1'b1, 5'd1,  1'b0, IDLE_LINES}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // line model state
    cmd_t              seq_cmd   = CMD_NONE;
    logic [4:0]        seq_phase = '0;
    logic [3:0]        seq_bits  = '0;
    logic [BYTE_W-1:0] seq_shift = '0;
    logic              seq_scl   = 1'b1;
    logic              seq_sda   = 1'b1;
    logic              seq_ack   = 1'b0;

    result_t     pending_ticks [$];
    logic        row_has_want = 1'b0;
    result_t     row_want = '0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned commands_done = 0;
    int unsigned bus_busy_starts = 0;
    int unsigned bytes_read = 0;

    i2c_master_bit_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400us;
        $display("timeout: %0d ticks sent, %0d results checked", ticks_sent, results_checked);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic result_t predict_tick(input item_t it);
        result_t    r;
        logic       running;
        logic       fin;
        logic       bus_low;
        logic       wrap;
        logic [7:0] rx;
        logic [4:0] ph;
        running = 1'b0;
        fin = 1'b0;
        bus_low = 1'b0;
        wrap = 1'b0;
        rx = '0;
        if (seq_cmd == CMD_NONE && it.op != CMD_NONE) begin
            seq_cmd = it.op;
            seq_phase = '0;
            seq_bits = '0;
            seq_shift = (it.op == CMD_WRITE) ? it.tx_byte : '0;
        end
        ph = seq_phase;
        if (seq_cmd != CMD_NONE) begin
            running = 1'b1;
            case (seq_cmd)
                CMD_START: begin
                    if (ph == 0) begin
                        seq_sda = 1'b1;
                        seq_scl = 1'b1;
                    end else if (ph == 1) begin
                        if (!it.sda_in) begin
                            bus_low = 1'b1;
                            fin = 1'b1;
                        end else begin
                            seq_sda = 1'b0;
                        end
                    end else begin
                        seq_scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (ph == 0) begin
                        seq_sda = 1'b0;
                        seq_scl = 1'b0;
                    end else if (ph == 1) begin
                        seq_scl = 1'b1;
                    end else begin
                        seq_sda = 1'b1;
                        fin = 1'b1;
                    end
                end
                CMD_ACK, CMD_NACK, CMD_WAIT: begin
                    if (ph == 0) begin
                        seq_scl = 1'b0;
                    end else if (ph == 1) begin
                        seq_sda = (seq_cmd != CMD_ACK);
                    end else if (ph == 2) begin
                        seq_scl = 1'b1;
                    end else begin
                        if (seq_cmd == CMD_WAIT) seq_ack = ~it.sda_in;
                        seq_scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (seq_bits >= BITS_PER_BYTE) begin
                        seq_scl = 1'b0;
                        fin = 1'b1;
                    end else if (ph == 0) begin
                        seq_scl = 1'b0;
                    end else if (ph == 1) begin
                        seq_sda = seq_shift[BYTE_W-1];
                        seq_shift = {seq_shift[BYTE_W-2:0], 1'b0};
                    end else begin
                        seq_scl = 1'b1;
                        seq_bits = seq_bits + 1'b1;
                        wrap = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (seq_bits >= BITS_PER_BYTE) begin
                        seq_shift = {seq_shift[BYTE_W-2:0], it.sda_in};
                        seq_scl = 1'b0;
                        rx = seq_shift;
                        fin = 1'b1;
                    end else if (ph == 0) begin
                        if (seq_bits == 0) seq_sda = 1'b1;
                        else seq_shift = {seq_shift[BYTE_W-2:0], it.sda_in};
                        seq_scl = 1'b0;
                    end else begin
                        seq_scl = 1'b1;
                        seq_bits = seq_bits + 1'b1;
                        wrap = 1'b1;
                    end
                end
                default: fin = 1'b1;
            endcase
            if (fin) begin
                seq_cmd = CMD_NONE;
                seq_phase = '0;
                seq_bits = '0;
            end else begin
                seq_phase = wrap ? 5'd0 : ph + 5'd1;
            end
        end
        r.scl_drive = seq_scl;
        r.sda_drive = seq_sda;
        r.busy_res  = running && !fin;
        r.done_res  = fin;
        r.status    = bus_low;
        r.ack_seen  = seq_ack;
        r.rx_byte   = rx;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t model;
        result_t want;
        result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                model = predict_tick(item_t'(s_tdata[$bits(item_t)-1:0]));
                pending_ticks.push_back(row_has_want ? row_want : model);
                ticks_sent++;
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                results_checked++;
                if (pending_ticks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transaction %h", got);
                end else begin
                    want = pending_ticks.pop_front();
                    if (want.done_res) commands_done++;
                    if (want.status) bus_busy_starts++;
                    if (want.done_res && want.rx_byte != 0) bytes_read++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d: want scl %b sda %b busy %b done %b st %b ",
                                      "ack %b rx %h, got scl %b sda %b busy %b done %b st %b ",
                                      "ack %b rx %h"}, results_checked,
                                     want.scl_drive, want.sda_drive, want.busy_res,
                                     want.done_res, want.status, want.ack_seen, want.rx_byte,
                                     got.scl_drive, got.sda_drive, got.busy_res,
                                     got.done_res, got.status, got.ack_seen, got.rx_byte);
                    end
                end
            end
        end
    end

    initial begin : receiver
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_checked >= 400) begin
                held = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else if (results_checked >= 1000 && results_checked < 1300) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 27);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic send_tick(input item_t it, input logic has_want, input result_t want,
                             input bit steady);
        while (!steady && $urandom_range(99) < 27) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = S_TDATA_W'(it);
        row_has_want = has_want;
        row_want = want;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        item_t       it;
        int unsigned n;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        foreach (dir_table[i]) begin
            for (n = 0; n < dir_table[i].reps; n++) begin
                it.op = dir_table[i].op;
                it.tx_byte = dir_table[i].tx;
                it.sda_in = dir_table[i].sda;
                send_tick(it, dir_table[i].has_want, dir_table[i].want, 1'b0);
            end
        end
        for (n = 0; n < RANDOM_TICKS; n++) begin
            if (n == 1500) begin
                s_tvalid = 1'b0;
                while (pending_ticks.size() != 0) @(posedge aclk);
                @(negedge aclk);
            end
            it.op = ($urandom_range(99) < 55) ? CMD_NONE : cmd_t'($urandom_range(7));
            it.tx_byte = BYTE_W'($urandom_range(255));
            it.sda_in = 1'($urandom_range(1));
            send_tick(it, 1'b0, IDLE_LINES, n >= 900 && n < 1200);
        end
        s_tvalid = 1'b0;
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_ticks.size() != 0) mismatches++;
        $display("ticks %0d, results %0d, commands completed %0d", ticks_sent,
                 results_checked, commands_done);
        $display("starts on a held bus %0d, nonzero bytes read %0d, mismatches %0d",
                 bus_busy_starts, bytes_read, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== i2c_master_bit_sequencer.f =====
hdl/i2cms_pkg.sv
hdl/i2cms_step.sv
hdl/i2c_master_bit_sequencer.sv
hdl/i2cms_checker.sv
verif/i2c_master_bit_sequencer_tb.sv
